// ===== rtl/core/dmwbc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmwbc_pkg
// Shared constants and types for the direct-mapped write-back cache.
// ----------------------------------------------------------------------------
package dmwbc_pkg;

    // Default geometry.
    localparam int ADDR_BITS_DEF    = 20;
    localparam int NUM_LINES_DEF    = 8;
    localparam int BLOCK_BYTES_DEF  = 16;
    localparam int ACCESS_BYTES_DEF = 4;

    // Byte lanes on the streaming ports, fixed by the word format.
    localparam int LANES  = 4;
    localparam int BYTE_W = 8;

    // Access kinds carried in the slave tuser bit.
    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_IDLE   = 2'd1,
        ST_LOOKUP = 2'd2,
        ST_FILL   = 2'd3
    } state_t;

endpackage

// ===== rtl/core/direct_mapped_writeback_cache.sv =====
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache
// Direct-mapped write-back, write-allocate cache with its backing memory.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel: tuser is the opcode (read or write),
//   tdata holds the byte address and four write bytes. Every request gives
//   one word on the m_ channel: tuser is the hit flag, tdata the four bytes
//   at offset..offset+3 of the block after the access (0 past the block).
//   A hit has its result in the output register after the lookup step: the
//   line memory read is issued in the accepting cycle, and the lookup step
//   merges, writes back and loads the output register. A miss adds a fill
//   step: in the lookup step a dirty victim row is written to the backing
//   memory in the same cycle as the new row is read, then the fill step
//   merges. A new request is accepted only once the block is back in idle.
//   Both stores move one whole block per cycle. One request is in flight at
//   a time; the next is taken as soon as the result sits in the output
//   register, even if it is not yet taken. When the output register is full
//   and m_tready is low, the block holds in its merge step until the slot
//   frees. After reset the backing memory is swept to zero, one block per
//   cycle, all 2^ADDR_BITS / BLOCK_BYTES rows (65536 with the defaults);
//   s_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache #(
    parameter int ADDR_BITS    = dmwbc_pkg::ADDR_BITS_DEF,
    parameter int NUM_LINES    = dmwbc_pkg::NUM_LINES_DEF,
    parameter int BLOCK_BYTES  = dmwbc_pkg::BLOCK_BYTES_DEF,
    parameter int ACCESS_BYTES = dmwbc_pkg::ACCESS_BYTES_DEF,
    localparam int S_DATA_W    =
        ((ADDR_BITS + dmwbc_pkg::LANES * dmwbc_pkg::BYTE_W + 7) / 8) * 8,
    localparam int M_DATA_W    = dmwbc_pkg::LANES * dmwbc_pkg::BYTE_W
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // address, write_byte0, write_byte1, write_byte2, write_byte3, zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    // opcode
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // read_byte0, read_byte1, read_byte2, read_byte3
    output logic [M_DATA_W-1:0] m_tdata,
    // hit
    output logic                m_tuser
);

    localparam int OFF_BITS  = $clog2(BLOCK_BYTES);
    localparam int LINE_BITS = $clog2(NUM_LINES);
    localparam int TAG_BITS  = ADDR_BITS - OFF_BITS - LINE_BITS;
    localparam int ROW_BITS  = ADDR_BITS - OFF_BITS;
    localparam int ROWS      = 1 << ROW_BITS;
    localparam int BLK_W     = BLOCK_BYTES * dmwbc_pkg::BYTE_W;
    localparam int LANES     = dmwbc_pkg::LANES;
    localparam int BYTE_W    = dmwbc_pkg::BYTE_W;

    // Storage: line data and backing memory, one block per row.
    logic [BLK_W-1:0] line_mem [NUM_LINES];
    logic [BLK_W-1:0] back_mem [ROWS];

    logic [BLK_W-1:0] lm_rdata_reg;
    logic [BLK_W-1:0] bk_rdata_reg;

    // Line state.
    logic [NUM_LINES-1:0] valid_reg;
    logic [NUM_LINES-1:0] dirty_reg;
    logic [TAG_BITS-1:0]  tag_reg [NUM_LINES];

    dmwbc_pkg::state_t state_reg, state_next;
    logic [ROW_BITS-1:0] clr_row_reg;

    // Request held while it is worked on.
    dmwbc_pkg::op_t             op_reg;
    logic [ADDR_BITS-1:0]       addr_reg;
    logic [LANES*BYTE_W-1:0]    wdata_reg;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_tuser_reg;

    logic                 accept;
    logic                 out_free;
    logic [LINE_BITS-1:0] in_slot;
    logic [OFF_BITS-1:0]  off;
    logic [LINE_BITS-1:0] slot;
    logic [TAG_BITS-1:0]  tag;
    logic                 hit;
    logic                 victim_dirty;
    logic                 upd;
    logic                 lm_rd_en;
    logic                 lm_we;
    logic                 bk_rd_en;
    logic                 bk_we;
    logic [ROW_BITS-1:0]  bk_waddr;
    logic [BLK_W-1:0]     bk_wdata;
    logic [BLK_W-1:0]     base_blk;
    logic [BLK_W-1:0]     merged;
    logic [OFF_BITS:0]    lane_idx [LANES];
    logic [M_DATA_W-1:0]  rd_bytes;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign in_slot  = s_tdata[OFF_BITS +: LINE_BITS];

    assign off  = addr_reg[OFF_BITS-1:0];
    assign slot = addr_reg[OFF_BITS +: LINE_BITS];
    assign tag  = addr_reg[ADDR_BITS-1 -: TAG_BITS];
    assign hit  = valid_reg[slot] && (tag_reg[slot] == tag);
    assign victim_dirty = valid_reg[slot] && dirty_reg[slot];

    // Next state and control.
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        lm_rd_en   = 1'b0;
        bk_rd_en   = 1'b0;
        bk_we      = 1'b0;
        bk_waddr   = clr_row_reg;
        bk_wdata   = '0;
        upd        = 1'b0;
        unique case (state_reg)
            dmwbc_pkg::ST_CLEAR:
            begin
                bk_we = 1'b1;
                if (&clr_row_reg)
                begin
                    state_next = dmwbc_pkg::ST_IDLE;
                end
            end
            dmwbc_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                lm_rd_en = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = dmwbc_pkg::ST_LOOKUP;
                end
            end
            dmwbc_pkg::ST_LOOKUP:
            begin
                if (hit)
                begin
                    if (out_free)
                    begin
                        upd        = 1'b1;
                        state_next = dmwbc_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    // A dirty victim goes out in the same cycle as the new block is read.
                    bk_we      = victim_dirty;
                    bk_waddr   = {tag_reg[slot], slot};
                    bk_wdata   = lm_rdata_reg;
                    bk_rd_en   = 1'b1;
                    state_next = dmwbc_pkg::ST_FILL;
                end
            end
            dmwbc_pkg::ST_FILL:
            begin
                if (out_free)
                begin
                    upd        = 1'b1;
                    state_next = dmwbc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dmwbc_pkg::ST_IDLE;
            end
        endcase
    end

    assign lm_we = upd && ((op_reg == dmwbc_pkg::OP_WRITE) || !hit);

    // Merge the write lanes into the block and pick the read lanes.
    always_comb
    begin
        base_blk = (state_reg == dmwbc_pkg::ST_FILL) ? bk_rdata_reg : lm_rdata_reg;
        merged   = base_blk;
        for (int k = 0; k < LANES; k++)
        begin
            lane_idx[k] = {1'b0, off} + (OFF_BITS+1)'(k);
            if ((op_reg == dmwbc_pkg::OP_WRITE) && (k < ACCESS_BYTES)
                && !lane_idx[k][OFF_BITS])
            begin
                merged[lane_idx[k][OFF_BITS-1:0]*BYTE_W +: BYTE_W] =
                    wdata_reg[k*BYTE_W +: BYTE_W];
            end
        end
        for (int k = 0; k < LANES; k++)
        begin
            if ((k < ACCESS_BYTES) && !lane_idx[k][OFF_BITS])
            begin
                rd_bytes[k*BYTE_W +: BYTE_W] =
                    merged[lane_idx[k][OFF_BITS-1:0]*BYTE_W +: BYTE_W];
            end
            else
            begin
                rd_bytes[k*BYTE_W +: BYTE_W] = '0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dmwbc_pkg::ST_CLEAR;
            clr_row_reg  <= '0;
            valid_reg    <= '0;
            dirty_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_LINES; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == dmwbc_pkg::ST_CLEAR)
            begin
                clr_row_reg <= clr_row_reg + 1'b1;
            end
            if (upd)
            begin
                valid_reg[slot] <= 1'b1;
                tag_reg[slot]   <= tag;
                if (op_reg == dmwbc_pkg::OP_WRITE)
                begin
                    dirty_reg[slot] <= 1'b1;
                end
                else if (!hit)
                begin
                    dirty_reg[slot] <= 1'b0;
                end
            end
            if (upd)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= dmwbc_pkg::op_t'(s_tuser);
            addr_reg  <= s_tdata[ADDR_BITS-1:0];
            wdata_reg <= s_tdata[ADDR_BITS +: LANES*BYTE_W];
        end
        if (upd)
        begin
            m_tdata_reg <= rd_bytes;
            m_tuser_reg <= hit;
        end
    end

    // Line data memory.
    always_ff @(posedge clk)
    begin
        if (lm_we)
        begin
            line_mem[slot] <= merged;
        end
        if (lm_rd_en)
        begin
            lm_rdata_reg <= line_mem[in_slot];
        end
    end

    // Backing memory.
    always_ff @(posedge clk)
    begin
        if (bk_we)
        begin
            back_mem[bk_waddr] <= bk_wdata;
        end
        if (bk_rd_en)
        begin
            bk_rdata_reg <= back_mem[addr_reg[ADDR_BITS-1:OFF_BITS]];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTH
    // An accepted request always goes straight to the lookup step.
    a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == dmwbc_pkg::ST_LOOKUP))
        else $error("accepted request did not enter lookup");

    // The backing memory is only written by the sweep or for a dirty victim.
    a_wb_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        (bk_we && (state_reg != dmwbc_pkg::ST_CLEAR)) |-> (victim_dirty && !hit))
        else $error("backing write without a dirty victim");

    // After an access the addressed line holds the request's tag.
    a_line_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        upd |=> (valid_reg[$past(slot)] && (tag_reg[$past(slot)] == $past(tag))))
        else $error("line not allocated after access");

    // The clearing sweep covers every row before requests are taken.
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(state_reg == dmwbc_pkg::ST_CLEAR) |-> $past(&clr_row_reg))
        else $error("clearing sweep ended early");

    // A new result is never loaded over one that is still waiting.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        upd |-> (!m_tvalid_reg || m_tready))
        else $error("result overwrote a waiting word");
`endif

endmodule
